// ===== hdl/mtks_pkg.sv =====
// ----------------------------------------------------------------------------
// Material text keyword scanner package
// Shared types, keyword tables and queue depths for the scanner.
// ----------------------------------------------------------------------------
package mtks_pkg;

    localparam int IN_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    localparam int KW_COUNT         = 7;
    localparam int KW_QUALITY_COUNT = 2;
    localparam int TOKEN_LEN_W      = 5;

    // Keyword text, right-aligned: the first character sits in the highest used byte.
    localparam logic [127:0] KW_TEXT [KW_COUNT] = '{
        "highquality", "uncompressed", "program", "vertexprogram",
        "fragmentprogram", "fp20program", "glslprogram"
    };
    localparam logic [TOKEN_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        5'd11, 5'd12, 5'd7, 5'd13, 5'd15, 5'd11, 5'd11
    };

    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
    localparam logic [7:0] CHAR_STAR    = 8'h2a;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5c;

    // One classified text byte, as passed from the front to the back.
    typedef struct packed {
        logic [7:0] lc_char;
        logic       is_ident;
        logic       is_bslash;
        logic       is_dquote;
        logic       is_squote;
        logic       is_slash;
        logic       is_star;
        logic       is_newline;
        logic       last;
    } item_t;

    typedef struct packed {
        logic quality_keyword;
        logic program_keyword;
        logic refused;
    } res_t;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_WORD   = 5'b00010,
        MODE_QUOTE  = 5'b00100,
        MODE_LINE   = 5'b01000,
        MODE_BLOCK  = 5'b10000
    } scan_mode_t;

    // Character of keyword k at position i; only meaningful for i below the keyword length.
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
        logic [3:0] pos;
        pos = KW_LEN[k][3:0] - 4'd1 - i;
        return KW_TEXT[k][{pos, 3'b000} +: 8];
    endfunction

endpackage

// ===== hdl/material_text_keyword_scanner.sv =====
// ----------------------------------------------------------------------------
// Material text keyword scanner
// Scans material text a byte per beat and reports keyword groups at its end.
// ----------------------------------------------------------------------------
// Text bytes are pushed one per beat, the final byte marked with last_byte, and
// exactly one result beat appears for each text, after its final byte passes
// the input queue and the result queue, or later while the result side stalls.
// The block sustains one byte per clock cycle: the back end consumes one
// classified byte a cycle from the input queue, which sets the rate, and
// stalls only while the result queue is full and a final byte waits.
module material_text_keyword_scanner
    import mtks_pkg::*;
#(
    parameter int IN_DEPTH  = IN_QUEUE_DEPTH,
    parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    input  logic       pop,
    output logic       empty,
    output logic       quality_keyword,
    output logic       program_keyword,
    output logic       refused
);

    item_t in_item;
    item_t q_item;
    logic  q_empty;
    logic  q_pop;
    res_t  res_in;
    res_t  res_out;
    logic  res_push;
    logic  res_full;

    mtks_front u_front (
        .text_byte (text_byte),
        .last_byte (last_byte),
        .item      (in_item)
    );

    mtks_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_item),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_item),
        .empty (q_empty)
    );

    mtks_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_empty (q_empty),
        .item_pop   (q_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    mtks_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign quality_keyword = res_out.quality_keyword;
    assign program_keyword = res_out.program_keyword;
    assign refused         = res_out.refused;

endmodule

// ===== hdl/mtks_front.sv =====
// ----------------------------------------------------------------------------
// Scanner front end
// Lowercases each incoming byte and decodes its character class.
// ----------------------------------------------------------------------------
module mtks_front
    import mtks_pkg::*;
(
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output item_t      item
);

    logic is_upper;
    logic is_lower;
    logic is_digit;

    assign is_upper = (text_byte >= 8'h41) && (text_byte <= 8'h5a);
    assign is_lower = (text_byte >= 8'h61) && (text_byte <= 8'h7a);
    assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);

    always_comb
    begin
        item.lc_char    = is_upper ? (text_byte | 8'h20) : text_byte;
        item.is_ident   = is_upper || is_lower || is_digit || (text_byte == 8'h5f);
        item.is_bslash  = (text_byte == CHAR_BSLASH);
        item.is_dquote  = (text_byte == CHAR_DQUOTE);
        item.is_squote  = (text_byte == CHAR_SQUOTE);
        item.is_slash   = (text_byte == CHAR_SLASH);
        item.is_star    = (text_byte == CHAR_STAR);
        item.is_newline = (text_byte == CHAR_NEWLINE);
        item.last       = last_byte;
    end

endmodule

// ===== hdl/mtks_fifo.sv =====
// ----------------------------------------------------------------------------
// Scanner queue
// Small first-word-fall-through queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mtks_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/mtks_back.sv =====
// ----------------------------------------------------------------------------
// Scanner back end
// Comment/word/string tracking, keyword matching, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module mtks_back
    import mtks_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  item_empty,
    output logic  item_pop,
    input  logic  res_full,
    output logic  res_push,
    output res_t  res
);

    scan_mode_t                mode_reg, mode_next;
    logic                      quote_single_reg, quote_single_next;
    logic                      slash_pending_reg, slash_pending_next;
    logic                      star_seen_reg, star_seen_next;
    logic [TOKEN_LEN_W-1:0]    tok_len_reg, tok_len_next;
    logic [KW_COUNT-1:0]       cand_reg, cand_next;
    logic                      quality_reg, quality_next;
    logic                      program_reg, program_next;
    logic                      refused_reg, refused_next;

    // A result beat may only leave when the result queue has room.
    assign item_pop = !item_empty && (!item.last || !res_full);
    assign res_push = item_pop && item.last;

    always_comb
    begin
        logic fall;
        logic handled;
        logic do_end;
        logic do_begin;
        logic do_feed;
        logic close_quote;
        logic fin_end;

        fall        = 1'b0;
        handled     = 1'b0;
        do_end      = 1'b0;
        do_begin    = 1'b0;
        do_feed     = 1'b0;
        fin_end     = 1'b0;
        close_quote = quote_single_reg ? item.is_squote : item.is_dquote;

        mode_next          = mode_reg;
        quote_single_next  = quote_single_reg;
        slash_pending_next = slash_pending_reg;
        star_seen_next     = star_seen_reg;
        tok_len_next       = tok_len_reg;
        cand_next          = cand_reg;
        quality_next       = quality_reg;
        program_next       = program_reg;
        refused_next       = refused_reg;

        if (!refused_reg)
        begin
            unique case (mode_reg)
                MODE_LINE:
                begin
                    if (item.is_newline)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_BLOCK:
                begin
                    if (star_seen_reg && item.is_slash)
                    begin
                        mode_next      = MODE_NORMAL;
                        star_seen_next = 1'b0;
                    end
                    else
                    begin
                        star_seen_next = item.is_star;
                    end
                end
                MODE_QUOTE:
                begin
                    if (close_quote)
                    begin
                        do_end    = 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                    else if (item.is_bslash)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        do_feed = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (item.is_ident)
                    begin
                        do_feed = 1'b1;
                    end
                    else
                    begin
                        do_end    = 1'b1;
                        mode_next = MODE_NORMAL;
                        fall      = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    fall      = 1'b1;
                end
            endcase

            if (fall)
            begin
                if (slash_pending_reg)
                begin
                    slash_pending_next = 1'b0;
                    if (item.is_slash)
                    begin
                        mode_next = MODE_LINE;
                        handled   = 1'b1;
                    end
                    else if (item.is_star)
                    begin
                        mode_next      = MODE_BLOCK;
                        star_seen_next = 1'b0;
                        handled        = 1'b1;
                    end
                end
                if (!handled)
                begin
                    if (item.is_bslash)
                    begin
                        refused_next = 1'b1;
                    end
                    else if (item.is_dquote || item.is_squote)
                    begin
                        mode_next         = MODE_QUOTE;
                        quote_single_next = item.is_squote;
                        do_begin          = 1'b1;
                    end
                    else if (item.is_slash)
                    begin
                        slash_pending_next = 1'b1;
                    end
                    else if (item.is_ident)
                    begin
                        mode_next = MODE_WORD;
                        do_begin  = 1'b1;
                        do_feed   = 1'b1;
                    end
                end
            end
        end

        // Close the current token, then open a fresh one, then take this byte into it.
        if (do_end)
        begin
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (cand_next[k] && (KW_LEN[k] == tok_len_next))
                begin
                    if (k < KW_QUALITY_COUNT)
                    begin
                        quality_next = 1'b1;
                    end
                    else
                    begin
                        program_next = 1'b1;
                    end
                end
            end
        end
        if (do_end || do_begin)
        begin
            tok_len_next = '0;
            cand_next    = '1;
        end
        if (do_feed)
        begin
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if ((tok_len_next >= KW_LEN[k]) ||
                    (kw_char(k, tok_len_next[3:0]) != item.lc_char))
                begin
                    cand_next[k] = 1'b0;
                end
            end
            if (tok_len_next != '1)
            begin
                tok_len_next = tok_len_next + 1'b1;
            end
        end

        // End of text: settle an open word, refuse an open string or block comment.
        if (item.last && !refused_next)
        begin
            if (mode_next == MODE_WORD)
            begin
                fin_end = 1'b1;
            end
            else if ((mode_next == MODE_QUOTE) || (mode_next == MODE_BLOCK))
            begin
                refused_next = 1'b1;
            end
        end
        if (fin_end)
        begin
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (cand_next[k] && (KW_LEN[k] == tok_len_next))
                begin
                    if (k < KW_QUALITY_COUNT)
                    begin
                        quality_next = 1'b1;
                    end
                    else
                    begin
                        program_next = 1'b1;
                    end
                end
            end
        end

        res.quality_keyword = quality_next || refused_next;
        res.program_keyword = program_next || refused_next;
        res.refused         = refused_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_NORMAL;
            quote_single_reg  <= 1'b0;
            slash_pending_reg <= 1'b0;
            star_seen_reg     <= 1'b0;
            tok_len_reg       <= '0;
            cand_reg          <= '1;
            quality_reg       <= 1'b0;
            program_reg       <= 1'b0;
            refused_reg       <= 1'b0;
        end
        else if (item_pop)
        begin
            if (item.last)
            begin
                mode_reg          <= MODE_NORMAL;
                quote_single_reg  <= 1'b0;
                slash_pending_reg <= 1'b0;
                star_seen_reg     <= 1'b0;
                tok_len_reg       <= '0;
                cand_reg          <= '1;
                quality_reg       <= 1'b0;
                program_reg       <= 1'b0;
                refused_reg       <= 1'b0;
            end
            else
            begin
                mode_reg          <= mode_next;
                quote_single_reg  <= quote_single_next;
                slash_pending_reg <= slash_pending_next;
                star_seen_reg     <= star_seen_next;
                tok_len_reg       <= tok_len_next;
                cand_reg          <= cand_next;
                quality_reg       <= quality_next;
                program_reg       <= program_next;
                refused_reg       <= refused_next;
            end
        end
    end

endmodule
